[rtl/plsp_pkg.sv]
// Package for the phone line status parser: byte codes, line codes, result
// codes, parser and executor state types, and the report and command tables.
// No dependencies.
package plsp_pkg;

  localparam int unsigned LINE_COUNT_DEF = 10;
  localparam int unsigned JOBQ_DEPTH = 2;

  // Received byte codes
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_CAP_I = 8'h49;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_I = 8'h69;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_O = 8'h6F;
  localparam logic [7:0] CH_LC_C = 8'h63;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Line codes and commands
  localparam logic [3:0] LC_UNPROBED = 4'd0;
  localparam logic [3:0] LC_IDLE = 4'd1;
  localparam logic [3:0] LC_MAIN = 4'd2;
  localparam logic [3:0] LC_CONF = 4'd3;
  localparam logic [3:0] LC_HOLD = 4'd4;
  localparam logic [3:0] LC_SHOLD = 4'd5;
  localparam logic [3:0] LC_BUSY = 4'd6;
  localparam logic [3:0] LC_SCR1 = 4'd7;
  localparam logic [3:0] LC_SCR2 = 4'd8;
  localparam logic [3:0] LC_ELSE = 4'd9;
  localparam logic [3:0] LC_RING = 4'd10;
  localparam logic [3:0] CMD_LOCK = 4'd11;
  localparam logic [3:0] CMD_BUTTON = 4'd12;

  // Console buttons
  localparam logic [3:0] BTN_REC_ON = 4'd2;
  localparam logic [3:0] BTN_REC_OFF = 4'd3;
  localparam logic [3:0] BTN_DUMP = 4'd4;

  // Result event codes
  localparam logic [2:0] EV_REPORT = 3'd0;
  localparam logic [2:0] EV_PROBE = 3'd1;
  localparam logic [2:0] EV_RECORD = 3'd2;
  localparam logic [2:0] EV_DUMP = 3'd3;
  localparam logic [2:0] EV_WATCHDOG = 3'd4;
  localparam logic [2:0] EV_MODE = 3'd5;

  // Report status, bank and console codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ON_AIR = 4'd1;
  localparam logic [3:0] ST_LOCKED = 4'd2;
  localparam logic [3:0] ST_HOLD = 4'd3;
  localparam logic [3:0] ST_SHOLD = 4'd4;
  localparam logic [3:0] ST_BUSIED = 4'd5;
  localparam logic [3:0] ST_HANDSET = 4'd6;
  localparam logic [3:0] ST_ELSEWHERE = 4'd7;
  localparam logic [3:0] ST_RINGING = 4'd8;
  localparam logic [1:0] BANK_MAIN = 2'd0;
  localparam logic [1:0] BANK_CONF = 2'd1;
  localparam logic [1:0] BANK_NONE = 2'd2;
  localparam logic [1:0] TAG_SCR1 = 2'd0;
  localparam logic [1:0] TAG_SCR2 = 2'd1;
  localparam logic [1:0] TAG_AIR = 2'd2;
  localparam logic [1:0] TAG_NONE = 2'd3;

  typedef enum logic [3:0] {
    PS_WAIT = 4'd0,
    PS_DIG1 = 4'd1,
    PS_DIG2 = 4'd2,
    PS_I    = 4'd3,
    PS_IN   = 4'd4,
    PS_INI  = 4'd5,
    PS_G    = 4'd6,
    PS_GO   = 4'd7,
    PS_GOT  = 4'd8
  } parse_state_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_DISP    = 2'd1,
    BK_RESTART = 2'd2
  } back_state_t;

  typedef struct packed {
    logic       restart;
    logic [3:0] cmd;
    logic [3:0] line;
  } job_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] line;
    logic [3:0] line_status;
    logic [1:0] bank;
    logic [1:0] console_tag;
    logic       flag;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] line_status;
    logic [1:0] bank;
    logic [1:0] console_tag;
  } report_t;

  function automatic logic [3:0] command_code(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      CH_F: c = LC_IDLE;
      CH_N: c = LC_MAIN;
      CH_C: c = LC_CONF;
      CH_H: c = LC_HOLD;
      CH_S: c = LC_SHOLD;
      CH_B: c = LC_BUSY;
      CH_P: c = LC_SCR1;
      CH_O: c = LC_SCR2;
      CH_E: c = LC_ELSE;
      CH_R: c = LC_RING;
      CH_L: c = CMD_LOCK;
      CH_U: c = CMD_BUTTON;
      default: c = LC_UNPROBED;
    endcase
    return c;
  endfunction

  function automatic report_t report_fields(input logic [3:0] code, input logic lk);
    report_t r;
    r = '{ok: 1'b1, line_status: ST_IDLE, bank: BANK_NONE, console_tag: TAG_NONE};
    case (code)
      LC_IDLE: r.line_status = ST_IDLE;
      LC_MAIN: begin
        r.line_status = lk ? ST_LOCKED : ST_ON_AIR;
        r.bank = BANK_MAIN;
        r.console_tag = TAG_AIR;
      end
      LC_CONF: begin
        r.line_status = lk ? ST_LOCKED : ST_ON_AIR;
        r.bank = BANK_CONF;
        r.console_tag = TAG_AIR;
      end
      LC_HOLD: r.line_status = ST_HOLD;
      LC_SHOLD: r.line_status = ST_SHOLD;
      LC_BUSY: r.line_status = ST_BUSIED;
      LC_SCR1: begin
        r.line_status = ST_HANDSET;
        r.console_tag = TAG_SCR1;
      end
      LC_SCR2: begin
        r.line_status = ST_HANDSET;
        r.console_tag = TAG_SCR2;
      end
      LC_ELSE: r.line_status = ST_ELSEWHERE;
      LC_RING: r.line_status = ST_RINGING;
      default: r = '{ok: 1'b0, line_status: ST_IDLE, bank: BANK_MAIN, console_tag: TAG_SCR1};
    endcase
    return r;
  endfunction

endpackage

[rtl/plsp_front.sv]
// Front end: byte parser that turns received bytes into dispatch and restart
// requests for the request queue. Depends on plsp_pkg.
module plsp_front import plsp_pkg::*; #(
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       job_push,
  output job_t       job
);

  parse_state_t state, state_next;
  logic [3:0]   pending_command, pending_command_next;
  logic [3:0]   cmd_code;
  logic [3:0]   digit;

  assign cmd_code = command_code(rx_byte);
  assign digit    = 4'(rx_byte - CH_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_WAIT;
      pending_command <= CMD_BUTTON;
    end else begin
      state <= state_next;
      pending_command <= pending_command_next;
    end
  end

  always_comb begin
    state_next = state;
    pending_command_next = pending_command;
    job_push = 1'b0;
    job = '{restart: 1'b0, cmd: pending_command, line: digit};
    if (accept) begin
      case (state)
        PS_WAIT: begin
          if (cmd_code != LC_UNPROBED) begin
            pending_command_next = cmd_code;
            state_next = PS_DIG1;
          end else if (rx_byte == CH_CAP_I) begin
            state_next = PS_I;
          end else if (rx_byte == CH_G) begin
            state_next = PS_G;
          end
        end
        PS_DIG1, PS_DIG2: begin
          if (state == PS_DIG1 && rx_byte == CH_ZERO) begin
            state_next = PS_DIG2;
          end else if (state == PS_DIG2 && rx_byte inside {[CH_ZERO:CH_NINE]}) begin
            state_next = PS_WAIT;
            job_push = (32'(digit) < LINE_COUNT);
          end else if (rx_byte == CH_CAP_I) begin
            state_next = PS_I;
          end else if (rx_byte == CH_G) begin
            state_next = PS_G;
          end else begin
            state_next = PS_WAIT;
          end
        end
        PS_I:  state_next = (rx_byte == CH_LC_N) ? PS_IN : PS_WAIT;
        PS_IN: state_next = (rx_byte == CH_LC_I) ? PS_INI : PS_WAIT;
        PS_G:  state_next = (rx_byte == CH_LC_O) ? PS_GO : PS_WAIT;
        PS_GO: state_next = (rx_byte == CH_LC_T) ? PS_GOT : PS_WAIT;
        PS_INI: begin
          job.restart = 1'b1;
          job_push = (rx_byte == CH_LC_T);
          state_next = PS_WAIT;
        end
        PS_GOT: begin
          job.restart = 1'b1;
          job_push = (rx_byte == CH_LC_C);
          state_next = PS_WAIT;
        end
        default: state_next = PS_WAIT;
      endcase
    end
  end

endmodule

[rtl/plsp_jobq.sv]
// Short request queue between the parser and the executor.
// Depends on plsp_pkg.
module plsp_jobq import plsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  localparam int unsigned PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             entries [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(JOBQ_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

[rtl/plsp_back.sv]
// Back end: runs queued requests on the line table and emits one result
// per cycle while the output register is free. Depends on plsp_pkg.
module plsp_back import plsp_pkg::*; #(
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  input  logic    out_pop,
  output logic    out_valid,
  output result_t out_res,
  output logic    out_last
);

  localparam int unsigned IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  back_state_t state, state_next;
  logic [3:0]  line_code [LINE_COUNT];
  logic        line_locked [LINE_COUNT];
  logic        watchdog, watchdog_next;
  logic [2:0]  mask, mask_next;
  logic [3:0]  line_reg, line_reg_next;
  logic [3:0]  step, step_next;
  result_t     third, third_next;

  logic             tbl_we;
  logic [3:0]       tbl_code;
  logic             tbl_lock;
  logic [IDX_W-1:0] idx;
  logic [3:0]       cur_code;
  logic             cur_lock;
  logic             emit_ok, emit;
  result_t          emit_res;
  logic             emit_last;
  report_t          rep;
  logic [3:0]       new_code;
  logic             new_lock;
  logic             third_ok;

  assign idx      = job.line[IDX_W-1:0];
  assign cur_code = line_code[idx];
  assign cur_lock = line_locked[idx];
  assign emit_ok  = !out_valid || out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        line_code[i] <= LC_UNPROBED;
        line_locked[i] <= 1'b0;
      end
    end else if (tbl_we) begin
      line_code[idx] <= tbl_code;
      line_locked[idx] <= tbl_lock;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      watchdog <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      watchdog <= watchdog_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask <= mask_next;
    line_reg <= line_reg_next;
    step <= step_next;
    third <= third_next;
    if (emit) begin
      out_res <= emit_res;
      out_last <= emit_last;
    end
  end

  always_comb begin
    state_next = state;
    watchdog_next = watchdog;
    mask_next = mask;
    line_reg_next = line_reg;
    step_next = step;
    third_next = third;
    job_pop = 1'b0;
    tbl_we = 1'b0;
    tbl_code = cur_code;
    tbl_lock = cur_lock;
    emit = 1'b0;
    emit_res = '0;
    emit_last = 1'b0;
    new_code = cur_code;
    new_lock = cur_lock;
    third_ok = 1'b0;
    rep = report_fields(new_code, new_lock);
    case (state)
      BK_IDLE: begin
        job_pop = job_valid;
        if (job_valid) begin
          if (job.restart) begin
            watchdog_next = 1'b1;
            step_next = '0;
            state_next = BK_RESTART;
          end else begin
            watchdog_next = 1'b0;
            line_reg_next = job.line;
            third_next = '0;
            third_next.line = job.line;
            if (job.cmd == CMD_BUTTON) begin
              case (job.line)
                BTN_REC_ON: begin
                  third_ok = 1'b1;
                  third_next.event_res = EV_RECORD;
                  third_next.flag = 1'b1;
                end
                BTN_REC_OFF: begin
                  third_ok = 1'b1;
                  third_next.event_res = EV_RECORD;
                end
                BTN_DUMP: begin
                  third_ok = 1'b1;
                  third_next.event_res = EV_DUMP;
                end
                default: third_ok = 1'b0;
              endcase
            end else begin
              if (job.cmd == CMD_LOCK) begin
                new_lock = 1'b1;
              end else begin
                new_code = job.cmd;
                if (job.cmd == LC_MAIN || job.cmd == LC_CONF || job.cmd == LC_IDLE) begin
                  new_lock = 1'b0;
                end
              end
              tbl_we = 1'b1;
              tbl_code = new_code;
              tbl_lock = new_lock;
              rep = report_fields(new_code, new_lock);
              third_ok = rep.ok;
              third_next.event_res = EV_REPORT;
              third_next.line_status = rep.line_status;
              third_next.bank = rep.bank;
              third_next.console_tag = rep.console_tag;
            end
            mask_next = {third_ok, watchdog, cur_code == LC_UNPROBED};
            state_next = (mask_next != 3'b000) ? BK_DISP : BK_IDLE;
          end
        end
      end
      BK_DISP: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (mask[0]) begin
            emit_res.event_res = EV_PROBE;
            emit_res.line = line_reg + 4'd1;
            mask_next = {mask[2:1], 1'b0};
          end else if (mask[1]) begin
            emit_res.event_res = EV_WATCHDOG;
            mask_next = {mask[2], 2'b00};
          end else begin
            emit_res = third;
            mask_next = 3'b000;
          end
          emit_last = (mask_next == 3'b000);
          if (emit_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_RESTART: begin
        if (emit_ok) begin
          emit = 1'b1;
          case (step)
            4'd0: begin
              emit_res.event_res = EV_WATCHDOG;
              emit_res.flag = 1'b1;
            end
            4'd1: emit_res.event_res = EV_MODE;
            default: begin
              emit_res.event_res = EV_PROBE;
              emit_res.line = step - 4'd2;
            end
          endcase
          emit_last = (step == 4'(LINE_COUNT + 1));
          step_next = step + 4'd1;
          if (emit_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

endmodule

[rtl/phone_line_status_parser.sv]
// Top level of the phone line status parser: byte parser, request queue and
// executor with its output register. Depends on plsp_pkg, plsp_front,
// plsp_jobq and plsp_back.
//
//  channel   direction  handshake        payload
//  bytes     in         push / full      rx_byte
//  results   out        pop / empty      event_res line line_status bank
//                                        console_tag flag last
//
// A byte is taken whenever the two-entry request queue has room. The executor
// loads a message, then emits its results (up to three); a restart emits a
// watchdog event, a mode event and a probe per line. Results go out one a
// cycle while the output register is free or popped. Reset returns the
// parser to command wait and marks every line unprobed in the same cycle.
// A stalled result holds the executor; bytes are taken until the queue fills.
module phone_line_status_parser import plsp_pkg::*; #(
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_res,
  output logic [3:0] line,
  output logic [3:0] line_status,
  output logic [1:0] bank,
  output logic [1:0] console_tag,
  output logic       flag,
  output logic       last
);

  logic    accept;
  logic    jq_push, jq_valid, jq_pop;
  job_t    jq_in, jq_head;
  logic    out_valid;
  result_t out_res;

  assign accept = push && !full;

  plsp_front #(.LINE_COUNT(LINE_COUNT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .job_push (jq_push),
    .job      (jq_in)
  );

  plsp_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (jq_push),
    .push_job (jq_in),
    .full     (full),
    .pop      (jq_pop),
    .valid    (jq_valid),
    .head     (jq_head)
  );

  plsp_back #(.LINE_COUNT(LINE_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (jq_valid),
    .job       (jq_head),
    .job_pop   (jq_pop),
    .out_pop   (pop && out_valid),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (last)
  );

  assign empty       = !out_valid;
  assign event_res   = out_res.event_res;
  assign line        = out_res.line;
  assign line_status = out_res.line_status;
  assign bank        = out_res.bank;
  assign console_tag = out_res.console_tag;
  assign flag        = out_res.flag;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_wd_on_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_WATCHDOG && flag) |-> !last)
    else $error("restart ended at watchdog event");

  a_mode_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_MODE) |-> !last)
    else $error("restart ended at mode command");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_PROBE) |-> (32'(line) <= LINE_COUNT))
    else $error("probe names a line out of range");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for phone_line_status_parser: directed byte table, then random messages,
// restarts and noise, checked against a line-state predictor held here.
// Depends on plsp_pkg and the parser RTL.
module tb import plsp_pkg::*; ();

  localparam int NLINES = LINE_COUNT_DEF;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] line;
    logic [3:0] line_status;
    logic [1:0] bank;
    logic [1:0] console_tag;
    logic       flag;
    logic       last;
  } ev_rec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic       n;
    ev_rec_t    r;
  } byte_row_t;

  localparam ev_rec_t NO_EV = '0;
  localparam ev_rec_t PROBE_TEN =
    {EV_PROBE, 4'd10, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0, 1'b1};
  localparam ev_rec_t PROBE_SIX =
    {EV_PROBE, 4'd6, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0, 1'b1};

  localparam byte_row_t DIR_ROWS [26] = '{
    {CH_L, 1'b0, 1'b0, NO_EV}, {CH_ZERO, 1'b0, 1'b0, NO_EV},
    {8'h39, 1'b1, 1'b1, PROBE_TEN},
    {CH_U, 1'b0, 1'b0, NO_EV}, {CH_ZERO, 1'b0, 1'b0, NO_EV},
    {8'h35, 1'b1, 1'b1, PROBE_SIX},
    {CH_CAP_I, 1'b0, 1'b0, NO_EV}, {CH_LC_N, 1'b0, 1'b0, NO_EV},
    {CH_LC_I, 1'b0, 1'b0, NO_EV}, {CH_LC_T, 1'b0, 1'b0, NO_EV},
    {CH_C, 1'b0, 1'b0, NO_EV}, {CH_ZERO, 1'b0, 1'b0, NO_EV}, {8'h33, 1'b0, 1'b0, NO_EV},
    {CH_L, 1'b0, 1'b0, NO_EV}, {CH_ZERO, 1'b0, 1'b0, NO_EV}, {8'h33, 1'b0, 1'b0, NO_EV},
    {8'hFF, 1'b1, 1'b0, NO_EV}, {8'h00, 1'b1, 1'b0, NO_EV},
    {CH_N, 1'b0, 1'b0, NO_EV}, {8'h31, 1'b1, 1'b0, NO_EV},
    {CH_S, 1'b0, 1'b0, NO_EV}, {CH_ZERO, 1'b0, 1'b0, NO_EV},
    {CH_G, 1'b0, 1'b0, NO_EV}, {CH_LC_O, 1'b0, 1'b0, NO_EV},
    {CH_LC_T, 1'b0, 1'b0, NO_EV}, {CH_LC_C, 1'b0, 1'b0, NO_EV}
  };

  localparam logic [7:0] CMD_CHARS [12] = '{
    CH_F, CH_N, CH_C, CH_H, CH_S, CH_B, CH_P, CH_O, CH_E, CH_R, CH_L, CH_U
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       empty;
  logic       pop;
  logic [2:0] event_res;
  logic [3:0] line;
  logic [3:0] line_status;
  logic [1:0] bank;
  logic [1:0] console_tag;
  logic       flag;
  logic       last;

  phone_line_status_parser dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .event_res(event_res), .line(line),
    .line_status(line_status), .bank(bank), .console_tag(console_tag),
    .flag(flag), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  parse_state_t prs_state;
  logic [3:0]   msg_cmd;
  logic [3:0]   code_of [NLINES];
  logic         locked [NLINES];
  logic         wdog_on;

  ev_rec_t   burst [$];
  ev_rec_t   events_due [$];
  byte_row_t stim [$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_restarts = 0;

  function automatic ev_rec_t mk_ev(logic [2:0] ev, logic [3:0] ln, logic [3:0] st,
                                    logic [1:0] bk, logic [1:0] ct, logic fl);
    ev_rec_t e;
    e = {ev, ln, st, bk, ct, fl, 1'b0};
    return e;
  endfunction

  function automatic void add_ev(ev_rec_t e);
    burst.insert(burst.size(), e);
  endfunction

  function automatic logic [3:0] cmd_of_byte(logic [7:0] b);
    logic [3:0] c;
    c = LC_UNPROBED;
    for (int k = 0; k < 12; k++)
      if (b == CMD_CHARS[k]) c = 4'(k + 1);
    return c;
  endfunction

  function automatic void line_report(logic [3:0] ln);
    logic [3:0] live;
    live = locked[ln] ? ST_LOCKED : ST_ON_AIR;
    case (code_of[ln])
      LC_IDLE:  add_ev(mk_ev(EV_REPORT, ln, ST_IDLE, BANK_NONE, TAG_NONE, 1'b0));
      LC_MAIN:  add_ev(mk_ev(EV_REPORT, ln, live, BANK_MAIN, TAG_AIR, 1'b0));
      LC_CONF:  add_ev(mk_ev(EV_REPORT, ln, live, BANK_CONF, TAG_AIR, 1'b0));
      LC_HOLD:  add_ev(mk_ev(EV_REPORT, ln, ST_HOLD, BANK_NONE, TAG_NONE, 1'b0));
      LC_SHOLD: add_ev(mk_ev(EV_REPORT, ln, ST_SHOLD, BANK_NONE, TAG_NONE, 1'b0));
      LC_BUSY:  add_ev(mk_ev(EV_REPORT, ln, ST_BUSIED, BANK_NONE, TAG_NONE, 1'b0));
      LC_SCR1:  add_ev(mk_ev(EV_REPORT, ln, ST_HANDSET, BANK_NONE, TAG_SCR1, 1'b0));
      LC_SCR2:  add_ev(mk_ev(EV_REPORT, ln, ST_HANDSET, BANK_NONE, TAG_SCR2, 1'b0));
      LC_ELSE:  add_ev(mk_ev(EV_REPORT, ln, ST_ELSEWHERE, BANK_NONE, TAG_NONE, 1'b0));
      LC_RING:  add_ev(mk_ev(EV_REPORT, ln, ST_RINGING, BANK_NONE, TAG_NONE, 1'b0));
      default: ;
    endcase
  endfunction

  function automatic void apply_message(logic [3:0] ln);
    if (ln < NLINES) begin
      if (code_of[ln] == LC_UNPROBED)
        add_ev(mk_ev(EV_PROBE, ln + 4'd1, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
      if (wdog_on) begin
        wdog_on = 1'b0;
        add_ev(mk_ev(EV_WATCHDOG, 4'd0, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
      end
      if (msg_cmd == CMD_BUTTON) begin
        case (ln)
          BTN_REC_ON:  add_ev(mk_ev(EV_RECORD, ln, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b1));
          BTN_REC_OFF: add_ev(mk_ev(EV_RECORD, ln, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
          BTN_DUMP:    add_ev(mk_ev(EV_DUMP, ln, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
          default: ;
        endcase
      end else begin
        if (msg_cmd == CMD_LOCK) begin
          locked[ln] = 1'b1;
        end else begin
          code_of[ln] = msg_cmd;
          if (msg_cmd == LC_MAIN || msg_cmd == LC_CONF || msg_cmd == LC_IDLE)
            locked[ln] = 1'b0;
        end
        line_report(ln);
      end
    end
  endfunction

  function automatic void restart_burst();
    n_restarts++;
    wdog_on = 1'b1;
    add_ev(mk_ev(EV_WATCHDOG, 4'd0, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b1));
    add_ev(mk_ev(EV_MODE, 4'd0, ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
    for (int k = 0; k < NLINES; k++)
      add_ev(mk_ev(EV_PROBE, 4'(k), ST_IDLE, BANK_MAIN, TAG_SCR1, 1'b0));
  endfunction

  function automatic void parse_rx(logic [7:0] b);
    logic [3:0] c;
    logic [7:0] d;
    burst.delete();
    c = cmd_of_byte(b);
    d = b - CH_ZERO;
    case (prs_state)
      PS_WAIT: begin
        if (c != LC_UNPROBED) begin
          msg_cmd = c;
          prs_state = PS_DIG1;
        end else if (b == CH_CAP_I) prs_state = PS_I;
        else if (b == CH_G) prs_state = PS_G;
      end
      PS_DIG1, PS_DIG2: begin
        if (prs_state == PS_DIG1 && b == CH_ZERO) prs_state = PS_DIG2;
        else if (prs_state == PS_DIG2 && b >= CH_ZERO && b <= CH_NINE) begin
          apply_message(d[3:0]);
          prs_state = PS_WAIT;
        end else if (b == CH_CAP_I) prs_state = PS_I;
        else if (b == CH_G) prs_state = PS_G;
        else prs_state = PS_WAIT;
      end
      PS_I:  prs_state = (b == CH_LC_N) ? PS_IN : PS_WAIT;
      PS_IN: prs_state = (b == CH_LC_I) ? PS_INI : PS_WAIT;
      PS_G:  prs_state = (b == CH_LC_O) ? PS_GO : PS_WAIT;
      PS_GO: prs_state = (b == CH_LC_T) ? PS_GOT : PS_WAIT;
      PS_INI: begin
        if (b == CH_LC_T) restart_burst();
        prs_state = PS_WAIT;
      end
      PS_GOT: begin
        if (b == CH_LC_C) restart_burst();
        prs_state = PS_WAIT;
      end
      default: prs_state = PS_WAIT;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    stim.insert(stim.size(), {b, 1'b0, 1'b0, NO_EV});
  endfunction

  task automatic check_result();
    ev_rec_t e;
    if (events_due.size() == 0) begin
      $error("result with no request waiting: event_res %0d line %0d", event_res, line);
      n_errors++;
    end else begin
      e = events_due.pop_front();
      n_checked++;
      if (event_res !== e.event_res) begin
        $error("event_res: expected %0d, got %0d", e.event_res, event_res);
        n_errors++;
      end
      if (line !== e.line) begin
        $error("line: expected %0d, got %0d", e.line, line);
        n_errors++;
      end
      if (line_status !== e.line_status) begin
        $error("line_status: expected %0d, got %0d", e.line_status, line_status);
        n_errors++;
      end
      if (bank !== e.bank) begin
        $error("bank: expected %0d, got %0d", e.bank, bank);
        n_errors++;
      end
      if (console_tag !== e.console_tag) begin
        $error("console_tag: expected %0d, got %0d", e.console_tag, console_tag);
        n_errors++;
      end
      if (flag !== e.flag) begin
        $error("flag: expected %0d, got %0d", e.flag, flag);
        n_errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        n_errors++;
      end
    end
  endtask

  // result side: random stalls, none for a stretch of results
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_result();
      pop <= (n_checked >= 100 && n_checked < 200) || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    int r;
    int k;
    prs_state = PS_WAIT;
    msg_cmd = CMD_BUTTON;
    wdog_on = 1'b0;
    for (int i = 0; i < NLINES; i++) begin
      code_of[i] = LC_UNPROBED;
      locked[i] = 1'b0;
    end
    foreach (DIR_ROWS[i]) stim.insert(stim.size(), DIR_ROWS[i]);
    while (stim.size() < 310) begin
      r = $urandom_range(99);
      k = $urandom_range(11);
      if (r < 68) begin
        add_byte(CMD_CHARS[k]);
        add_byte(CH_ZERO);
        add_byte(CH_ZERO + 8'($urandom_range(9)));
      end else if (r < 73) begin
        if (r[0]) begin
          add_byte(CH_CAP_I); add_byte(CH_LC_N); add_byte(CH_LC_I); add_byte(CH_LC_T);
        end else begin
          add_byte(CH_G); add_byte(CH_LC_O); add_byte(CH_LC_T); add_byte(CH_LC_C);
        end
      end else if (r < 80) begin
        add_byte(CMD_CHARS[k]);
        add_byte(8'($urandom_range(255)));
      end else if (r < 86) begin
        add_byte(CMD_CHARS[k]);
        add_byte(CH_ZERO);
        add_byte(8'($urandom_range(255)));
      end else if (r < 90) begin
        add_byte(r[0] ? CH_CAP_I : CH_G);
        add_byte(r[1] ? 8'($urandom_range(255)) : (r[0] ? CH_LC_N : CH_LC_O));
        add_byte(8'($urandom_range(255)));
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end

    rst = 1'b1;
    push = 1'b0;
    rx_byte = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // request side: random gaps, none for a stretch of bytes
    foreach (stim[i]) begin
      if (!(i >= 150 && i < 230) && $urandom_range(99) < 13) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push <= 1'b1;
      rx_byte <= stim[i].b;
      do @(posedge clk); while (full);
      parse_rx(stim[i].b);
      if (stim[i].typed) begin
        burst.delete();
        if (stim[i].n) add_ev(stim[i].r);
      end
      foreach (burst[j]) events_due.insert(events_due.size(), burst[j]);
    end
    push <= 1'b0;

    while (events_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d bytes, 26 of them directed, with %0d restarts", stim.size(),
             n_restarts);
    $display("checked %0d results, %0d field mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d results outstanding", events_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
